// ===== hdl/pla_pkg.sv =====
// ----------------------------------------------------------------------------
// Proximity level alarm package
// Shared payload types, configuration register map, reset values,
// distance scaling constants and the melody note table.
// ----------------------------------------------------------------------------
package pla_pkg;

  // Input transaction
  typedef struct packed {
    logic [19:0] echo_us;
    logic        button_pressed;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [14:0] distance_cm;
    logic [2:0]  zone_level;
    logic [4:0]  led_mask;
    logic        tone_on;
    logic [9:0]  tone_hz;
  } out_item_t;

  // Configuration register map
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOUND1 = 3'd0,
    CFG_BOUND2 = 3'd1,
    CFG_BOUND3 = 3'd2,
    CFG_BOUND4 = 3'd3,
    CFG_FAR    = 3'd4,
    CFG_HYST   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0][7:0] bound;
    logic [7:0]      far_start;
    logic [3:0]      margin_cm;
  } cfg_t;

  // Boundary shift codes
  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_UP   = 2'd1,
    SHIFT_DOWN = 2'd2
  } shift_e;

  localparam logic [7:0] BOUND1_RST = 8'd10;
  localparam logic [7:0] BOUND2_RST = 8'd20;
  localparam logic [7:0] BOUND3_RST = 8'd30;
  localparam logic [7:0] BOUND4_RST = 8'd40;
  localparam logic [7:0] FAR_RST    = 8'd50;
  localparam logic [3:0] HYST_RST   = 4'd1;

  // Classified reading passed from the front end to the zone tracker.
  // For each boundary: distance compared against the lowered, nominal and
  // raised edge.
  typedef struct packed {
    logic [14:0] dist_cm;
    logic [3:0]  le_dn;
    logic [3:0]  le_nom;
    logic [3:0]  le_up;
    logic        far_ok;
    logic        button;
  } cls_item_t;

  // Distance: floor(x / 291) with x = (echo >> 1) * 10 < 2^23, done as
  // (x * ceil(2^32 / 291)) >> 32. The rounding error 62 * x stays below
  // 2^32, so the quotient is exact over the whole input range.
  localparam logic [23:0]  DIV_RECIP    = 24'd14759338;
  localparam int unsigned  RECIP_SHIFT  = 32;
  localparam logic [14:0]  MAX_RANGE_CM = 15'd4000;

  localparam int unsigned  QUEUE_DEPTH  = 2;
  localparam int unsigned  MELODY_LEN_DEF = 96;
  localparam int unsigned  ROM_DEPTH    = 96;
  localparam logic [2:0]   MAX_LEVEL    = 3'd5;

  localparam logic [9:0] MELODY_ROM [ROM_DEPTH] = '{
    10'd466, 10'd466, 10'd466, 10'd466, 10'd466, 10'd466, 10'd466, 10'd466,
    10'd587, 10'd587, 10'd587, 10'd587, 10'd523, 10'd523, 10'd523, 10'd523,
    10'd698, 10'd698, 10'd698, 10'd698, 10'd784, 10'd784, 10'd784, 10'd784,
    10'd784, 10'd784, 10'd784, 10'd784, 10'd784, 10'd784, 10'd784, 10'd784,
    10'd523, 10'd466, 10'd440, 10'd349, 10'd392, 10'd0,   10'd392, 10'd587,
    10'd523, 10'd0,   10'd466, 10'd0,   10'd440, 10'd0,   10'd440, 10'd440,
    10'd523, 10'd0,   10'd466, 10'd440, 10'd392, 10'd0,   10'd392, 10'd932,
    10'd880, 10'd932, 10'd880, 10'd932, 10'd392, 10'd0,   10'd392, 10'd932,
    10'd880, 10'd932, 10'd880, 10'd932, 10'd392, 10'd0,   10'd392, 10'd587,
    10'd523, 10'd0,   10'd466, 10'd0,   10'd440, 10'd0,   10'd440, 10'd440,
    10'd523, 10'd0,   10'd466, 10'd440, 10'd392, 10'd0,   10'd392, 10'd932,
    10'd880, 10'd932, 10'd880, 10'd932, 10'd392, 10'd0,   10'd392, 10'd932
  };

  // Note lookup; an index past the table is a rest
  function automatic logic [9:0] melody_note(logic [7:0] idx);
    logic [9:0] note;
    note = 10'd0;
    if (idx < 8'(ROM_DEPTH)) begin
      note = MELODY_ROM[idx[6:0]];
    end
    return note;
  endfunction

endpackage

// ===== hdl/pla_front.sv =====
// ----------------------------------------------------------------------------
// Proximity level alarm front end
// Converts the echo time to centimetres and compares the distance against
// every candidate boundary edge.
// ----------------------------------------------------------------------------
module pla_front
  import pla_pkg::*;
(
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output cls_item_t cls_o
);

  logic [18:0] half_echo;
  logic [22:0] scaled;
  logic [46:0] prod;
  logic [14:0] dist_cm;

  assign half_echo = item_i.echo_us[19:1];
  assign scaled    = {1'b0, half_echo, 3'b000} + {3'b000, half_echo, 1'b0};
  assign prod      = {24'd0, scaled} * {23'd0, DIV_RECIP};
  assign dist_cm   = prod[46:RECIP_SHIFT];

  always_comb begin
    logic [8:0] b;
    logic [8:0] m;
    cls_o.dist_cm = dist_cm;
    cls_o.button  = item_i.button_pressed;
    cls_o.far_ok  = (dist_cm >= {7'd0, cfg_i.far_start}) && (dist_cm <= MAX_RANGE_CM);
    m = {5'd0, cfg_i.margin_cm};
    for (int k = 0; k < 4; k++) begin
      b = {1'b0, cfg_i.bound[k]};
      cls_o.le_nom[k] = dist_cm <= {6'd0, b};
      cls_o.le_up[k]  = dist_cm <= {6'd0, b + m};
      // A lowered edge below zero is never reached
      cls_o.le_dn[k]  = (b >= m) && (dist_cm <= {6'd0, b - m});
    end
  end

endmodule

// ===== hdl/pla_queue.sv =====
// ----------------------------------------------------------------------------
// Proximity level alarm queue
// Two-entry queue between the front end and the zone tracker.
// ----------------------------------------------------------------------------
module pla_queue
  import pla_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output cls_item_t data_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cls_item_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

// ===== hdl/pla_back.sv =====
// ----------------------------------------------------------------------------
// Proximity level alarm zone tracker
// Holds the zone, hysteresis shifts, button and melody state, and drives
// the result register.
// ----------------------------------------------------------------------------
module pla_back
  import pla_pkg::*;
#(
  parameter int unsigned MELODY_LEN = MELODY_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cls_item_t q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned NoteW = (MELODY_LEN > 1) ? $clog2(MELODY_LEN) : 1;

  logic [2:0]       level_q, level_d;
  shift_e [3:0]     shift_q, shift_d;
  logic             seen_q, seen_d;
  logic             silenced_q, silenced_d;
  logic [NoteW-1:0] note_q, note_d;
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic             go;
  logic [3:0]       le;
  logic [4:0]       zone;

  assign go          = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = go;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Pick each boundary's compare by its current shift
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      unique case (shift_q[k])
        SHIFT_UP:   le[k] = q_data_i.le_up[k];
        SHIFT_DOWN: le[k] = q_data_i.le_dn[k];
        default:    le[k] = q_data_i.le_nom[k];
      endcase
    end
    zone[0] = le[0];
    zone[1] = !le[0] && le[1];
    zone[2] = !le[0] && !le[1] && le[2];
    zone[3] = !le[0] && !le[1] && !le[2] && le[3];
    zone[4] = !(|le) && q_data_i.far_ok;
  end

  always_comb begin
    level_d    = level_q;
    shift_d    = shift_q;
    seen_d     = seen_q;
    silenced_d = silenced_q;
    note_d     = note_q;
    out_d.distance_cm = q_data_i.dist_cm;
    out_d.tone_on     = 1'b0;
    out_d.tone_hz     = 10'd0;

    priority if (zone[0]) begin
      if (level_q == 3'd2) shift_d[0] = SHIFT_UP;
      level_d = 3'd1;
      if (q_data_i.button != seen_q) begin
        seen_d = q_data_i.button;
        if (q_data_i.button) silenced_d = 1'b1;
      end
      if (!silenced_d) begin
        out_d.tone_on = 1'b1;
        out_d.tone_hz = melody_note(8'(note_q));
        note_d = (note_q == NoteW'(MELODY_LEN - 1)) ? '0 : note_q + 1'b1;
      end
    end else if (zone[1] || zone[2] || zone[3] || zone[4]) begin
      // Entering from below lowers the boundary underneath, entering from
      // above raises the boundary overhead
      for (int k = 1; k < 5; k++) begin
        if (zone[k]) begin
          level_d = 3'(k + 1);
          if (level_q == 3'(k)) shift_d[k-1] = SHIFT_DOWN;
          if (k < 4 && level_q == 3'(k + 2)) shift_d[k] = SHIFT_UP;
        end
      end
      silenced_d = 1'b0;
      note_d     = '0;
    end else begin
      level_d = level_q;
    end

    out_d.zone_level = level_d;
    out_d.led_mask   = ~(5'h1f << level_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= 3'd0;
      shift_q     <= {4{SHIFT_NONE}};
      seen_q      <= 1'b1;
      silenced_q  <= 1'b0;
      note_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        level_q    <= level_d;
        shift_q    <= shift_d;
        seen_q     <= seen_d;
        silenced_q <= silenced_d;
        note_q     <= note_d;
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= out_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= MAX_LEVEL)
    else $error("zone level out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    9'(note_q) < 9'(MELODY_LEN))
    else $error("note index past melody length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.tone_on || out_q.tone_hz == 10'd0))
    else $error("tone frequency without tone");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones(out_q.led_mask) == 32'(out_q.zone_level)))
    else $error("LED mask does not match level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && silenced_q && zone[0]) |=> !out_q.tone_on)
    else $error("tone while silenced");

endmodule

// ===== hdl/proximity_level_alarm_unit.sv =====
// ----------------------------------------------------------------------------
// Proximity level alarm unit
// Turns ultrasonic echo times into distance, LED level and alarm melody.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one reading
//   per transaction: echo time in microseconds and the stop-button level.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly
//   one result per reading, in order: distance, zone level, LED mask and the
//   melody note played for that reading.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) set the zone
//   bounds, the zone-five start and the hysteresis margin; write them only
//   while no transaction is in flight. Unknown indexes are dropped.
// Dataflow:
//   A reading is converted and classified in the cycle it is accepted and
//   written into a two-entry queue; the zone tracker pops it from the queue
//   and registers the result, which is presented on the output channel.
//   One reading per cycle is sustained while the output is not stalled; the
//   zone state in the tracker is updated as each reading is taken, so
//   back-to-back readings see their predecessor's state.
// Reset: clears zone, hysteresis shifts and melody state; registers return
//   to 10/20/30/40/50 cm with a 1 cm margin.
// Stall: a stalled result is held; the queue keeps absorbing readings until
//   it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
module proximity_level_alarm_unit
  import pla_pkg::*;
#(
  parameter int unsigned MELODY_LEN = MELODY_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  cls_item_t cls;
  cls_item_t q_data;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      push;

  // Configuration registers; writes to unmapped indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bound     <= {BOUND4_RST, BOUND3_RST, BOUND2_RST, BOUND1_RST};
      cfg_q.far_start <= FAR_RST;
      cfg_q.margin_cm <= HYST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOUND1: cfg_q.bound[0]  <= cfg_data_i;
        CFG_BOUND2: cfg_q.bound[1]  <= cfg_data_i;
        CFG_BOUND3: cfg_q.bound[2]  <= cfg_data_i;
        CFG_BOUND4: cfg_q.bound[3]  <= cfg_data_i;
        CFG_FAR:    cfg_q.far_start <= cfg_data_i;
        CFG_HYST:   cfg_q.margin_cm <= cfg_data_i[3:0];
        default: begin
          // drop unmapped writes
        end
      endcase
    end
  end

  // Accept whenever the queue has room
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  pla_front u_front (
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .cls_o  (cls)
  );

  pla_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  pla_back #(
    .MELODY_LEN (MELODY_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
